/* sv/hopper_feed_consumption_totalizer_macros.svh */
// assertion helpers used by the top-level rtl file
`ifndef HOPPER_FEED_CONSUMPTION_TOTALIZER_MACROS_SVH
`define HOPPER_FEED_CONSUMPTION_TOTALIZER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define HFCT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define HFCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* sv/hfct_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hfct_pkg
// types and constants of the hopper feed consumption totalizer
// ---------------------------------------------------------------------------
package hfct_pkg;

  localparam int unsigned WeightW = 32;
  localparam int unsigned CountW  = 8;
  localparam int unsigned PhaseW  = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [WeightW-1:0] DeltaThresholdRst = 32'd100;
  localparam logic [CountW-1:0]  ConfirmCountRst   = 8'd10;
  localparam logic [WeightW-1:0] TotalLimitRst     = 32'hFFFF_FFFF;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgDeltaThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgConfirmCount   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTotalLimit     = 2'd2;

  // packed width of the result word, padded up to whole bytes
  localparam int unsigned ResultW    = 3 * WeightW + PhaseW + CountW;
  localparam int unsigned ResultPadW = ((ResultW + 7) / 8) * 8;

  typedef enum logic [PhaseW-1:0] {
    PH_POWER_ON   = 3'd0,
    PH_JUDGE      = 3'd1,
    PH_DROP_JUDGE = 3'd2,
    PH_DROP       = 3'd3,
    PH_RISE_JUDGE = 3'd4,
    PH_RISE       = 3'd5
  } phase_e;

  typedef struct packed {
    logic [WeightW-1:0] delta_threshold;
    logic [CountW-1:0]  confirm_count;
    logic [WeightW-1:0] total_limit;
  } cfg_t;

  typedef struct packed {
    phase_e             phase;
    logic [WeightW-1:0] reference;
    logic [CountW-1:0]  count;
    logic [WeightW-1:0] total;
    logic [WeightW-1:0] diff;
  } state_t;

endpackage

/* sv/hfct_cfg_regs.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hfct_cfg_regs
// configuration register file, written by index over its own channel
// ---------------------------------------------------------------------------
module hfct_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [hfct_pkg::CfgIdxW-1:0] wr_index_i,
  input  logic [hfct_pkg::WeightW-1:0] wr_data_i,
  output hfct_pkg::cfg_t              cfg_o
);

  hfct_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delta_threshold <= hfct_pkg::DeltaThresholdRst;
      cfg_q.confirm_count   <= hfct_pkg::ConfirmCountRst;
      cfg_q.total_limit     <= hfct_pkg::TotalLimitRst;
    end else if (wr_en_i) begin
      // indexes past the list are dropped
      if (wr_index_i == hfct_pkg::CfgDeltaThreshold) begin
        cfg_q.delta_threshold <= wr_data_i;
      end else if (wr_index_i == hfct_pkg::CfgConfirmCount) begin
        cfg_q.confirm_count <= wr_data_i[hfct_pkg::CountW-1:0];
      end else if (wr_index_i == hfct_pkg::CfgTotalLimit) begin
        cfg_q.total_limit <= wr_data_i;
      end
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/hfct_step.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hfct_step
// next state of the phase machine for one clamped weight sample
// ---------------------------------------------------------------------------
module hfct_step (
  input  hfct_pkg::cfg_t               cfg_i,
  input  hfct_pkg::state_t             state_i,
  input  logic [hfct_pkg::WeightW-1:0] weight_i,
  output hfct_pkg::state_t             state_o
);

  logic [hfct_pkg::WeightW-1:0] drop_diff;
  logic [hfct_pkg::WeightW-1:0] rise_diff;
  logic [hfct_pkg::WeightW-1:0] sum;
  logic [hfct_pkg::CountW-1:0]  count_inc;

  assign drop_diff = state_i.reference - weight_i;
  assign rise_diff = weight_i - state_i.reference;
  assign sum       = state_i.total + drop_diff;
  // counter saturates at the confirm count
  assign count_inc = (state_i.count < cfg_i.confirm_count) ?
                     state_i.count + 1'b1 : state_i.count;

  always_comb begin
    state_o = state_i;
    unique case (state_i.phase)
      hfct_pkg::PH_POWER_ON: begin
        state_o.reference = weight_i;
        state_o.phase     = hfct_pkg::PH_JUDGE;
      end
      hfct_pkg::PH_JUDGE: begin
        state_o.count = '0;
        state_o.diff  = '0;
        state_o.phase = (state_i.reference > weight_i) ?
                        hfct_pkg::PH_DROP_JUDGE : hfct_pkg::PH_RISE_JUDGE;
      end
      hfct_pkg::PH_DROP_JUDGE: begin
        if (state_i.reference >= weight_i) begin
          state_o.diff = drop_diff;
          if (drop_diff > cfg_i.delta_threshold) begin
            state_o.count = count_inc;
            if (count_inc == cfg_i.confirm_count) begin
              state_o.phase = hfct_pkg::PH_DROP;
            end
          end
        end else begin
          state_o.phase = hfct_pkg::PH_JUDGE;
          state_o.count = '0;
        end
      end
      hfct_pkg::PH_RISE_JUDGE: begin
        if (state_i.reference <= weight_i) begin
          state_o.diff = rise_diff;
          if (rise_diff > cfg_i.delta_threshold) begin
            state_o.count = count_inc;
            if (count_inc == cfg_i.confirm_count) begin
              state_o.phase = hfct_pkg::PH_RISE;
            end
          end
        end else begin
          state_o.phase = hfct_pkg::PH_JUDGE;
          state_o.count = '0;
        end
      end
      hfct_pkg::PH_DROP: begin
        state_o.diff      = drop_diff;
        state_o.total     = (sum > cfg_i.total_limit) ? sum - cfg_i.total_limit : sum;
        state_o.reference = weight_i;
        state_o.phase     = hfct_pkg::PH_JUDGE;
      end
      hfct_pkg::PH_RISE: begin
        state_o.reference = weight_i;
        state_o.phase     = hfct_pkg::PH_JUDGE;
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

/* sv/hopper_feed_consumption_totalizer.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hopper_feed_consumption_totalizer
// totals feed drawn from a hopper from a stream of scale weight samples
// ---------------------------------------------------------------------------
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  weight sample, 32 bit
//  m_axis    out  m_axis_tvalid/m_axis_tready  total, phase, count, ref, diff
//  cfg       in   cfg_valid_i/cfg_ready_o      register index and data
//
//  one sample per cycle while results drain; a taken word passes the input
//  register, then the phase step into the result register
//  reset clears the phase machine, total and reference and loads the
//  register defaults; no clearing pass
//  a stalled result holds the step stage; the input register still takes
//  a word while it is empty, then tready drops until the result moves
//  cfg is always ready, unchecked; user writes only while the stream is quiet
// ---------------------------------------------------------------------------
module hopper_feed_consumption_totalizer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // stream in
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [hfct_pkg::WeightW-1:0]    s_axis_tdata,   // [31:0] weight_sample
  // stream out
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] consumed_total, [34:32] phase, [42:35] excursion_count,
  // [74:43] reference_weight, [106:75] last_difference, rest zero
  output logic [hfct_pkg::ResultPadW-1:0] m_axis_tdata,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [hfct_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [hfct_pkg::WeightW-1:0]    cfg_data_i
);

  hfct_pkg::cfg_t               cfg;
  hfct_pkg::state_t             state_q, state_d;

  logic                         in_valid_q;
  logic [hfct_pkg::WeightW-1:0] in_weight_q;
  logic                         out_valid_q, out_valid_d;
  logic                         step_en;
  logic                         in_take;

  // config port never back-pressures
  assign cfg_ready_o = 1'b1;

  hfct_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // step fires when a word waits and the result slot is free or leaving
  assign step_en       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step_en;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // input register, negative samples clamped to zero on entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_weight_q <= s_axis_tdata[hfct_pkg::WeightW-1] ? '0 : s_axis_tdata;
    end
  end

  hfct_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .weight_i (in_weight_q),
    .state_o  (state_d)
  );

  // the state itself is the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase     <= hfct_pkg::PH_POWER_ON;
      state_q.reference <= '0;
      state_q.count     <= '0;
      state_q.total     <= '0;
      state_q.diff      <= '0;
    end else if (step_en) begin
      state_q <= state_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step_en) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(hfct_pkg::ResultPadW - hfct_pkg::ResultW){1'b0}},
                          state_q.diff, state_q.reference, state_q.count,
                          state_q.phase, state_q.total};

  `include "hopper_feed_consumption_totalizer_macros.svh"

  // state only moves when a word is stepped
  `HFCT_ASSERT_NEXT(a_state_held, clk_i, rst_ni, !step_en, $stable(state_q))
  // the counter is never set before the first sample
  `HFCT_ASSERT_SAME(a_poweron_count, clk_i, rst_ni,
                    state_q.phase == hfct_pkg::PH_POWER_ON, state_q.count == '0)
  // a rise never touches the total
  `HFCT_ASSERT_NEXT(a_rise_total, clk_i, rst_ni,
                    step_en && state_q.phase == hfct_pkg::PH_RISE,
                    $stable(state_q.total))

endmodule
